/* rtl/sliding_window_extremum_with_position_top_defines.svh */
// Assertion macros shared by the sliding-window extremum RTL.
`ifndef SLIDING_WINDOW_EXTREMUM_WITH_POSITION_TOP_DEFINES_SVH
`define SLIDING_WINDOW_EXTREMUM_WITH_POSITION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SWMX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Expression must never be true outside reset.
`define SWMX_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define SWMX_ASSERT(lbl, prop, msg)
`define SWMX_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/swmx_pkg.sv */
// Shared types and constants of the sliding-window extremum block.
package swmx_pkg;

   // defaults for the top-level parameters
   localparam int MAX_RADIUS_DEFAULT  = 16;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // register widths and the config port
   localparam int RADIUS_BITS    = 5;
   localparam int CSR_DATA_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_RADIUS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_MAX      = CSR_INDEX_BITS'(1);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controls for every cell of the ring
   typedef struct packed {
      logic shift_en;   // take the neighbor on the newer side (new item)
      logic rotate_en;  // take the neighbor on the older side (scan step)
   } cell_ctrl_type;

   // controls for the compare unit
   typedef struct packed {
      logic load_first; // newest sample seeds the running extremum
      logic update_en;  // current tap lies inside the window
   } scan_ctrl_type;

endpackage

/* rtl/swmx_cell.sv */
// One storage cell of the sample ring: shifts on a new item, rotates on a scan step.
module swmx_cell #(
   parameter int SAMPLE_BITS = swmx_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  swmx_pkg::cell_ctrl_type       ctrl,
   input  logic [SAMPLE_BITS-1:0]        newer_value,
   input  logic [SAMPLE_BITS-1:0]        older_value,
   output logic [SAMPLE_BITS-1:0]        value
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;

   // shift moves samples one place older, rotate brings the older neighbor forward
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_en) begin
         value_in = newer_value;
      end else if (ctrl.rotate_en) begin
         value_in = older_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* rtl/swmx_scan.sv */
// Running compare unit: keeps the best sample and its age while the ring rotates past it.
module swmx_scan #(
   parameter int SAMPLE_BITS = swmx_pkg::SAMPLE_BITS_DEFAULT,
   parameter int AGE_BITS    = 6
) (
   input  logic                      clock,
   input  swmx_pkg::scan_ctrl_type   ctrl,
   input  logic                      find_max,
   input  logic [SAMPLE_BITS-1:0]    tap,
   input  logic [AGE_BITS-1:0]       step,
   output logic [SAMPLE_BITS-1:0]    best,
   output logic [AGE_BITS-1:0]       best_age
);

   logic [SAMPLE_BITS-1:0] best_ff;
   logic [SAMPLE_BITS-1:0] best_in;
   logic [AGE_BITS-1:0]    age_ff;
   logic [AGE_BITS-1:0]    age_in;
   logic                   better;

   // ties go to the older sample, so equal values also replace
   assign better = find_max ? (tap >= best_ff) : (tap <= best_ff);

   always_comb begin
      best_in = best_ff;
      age_in  = age_ff;
      if (ctrl.load_first) begin
         best_in = tap;
         age_in  = '0;
      end else if (ctrl.update_en && better) begin
         best_in = tap;
         age_in  = step;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      age_ff  <= age_in;
   end

   assign best     = best_ff;
   assign best_age = age_ff;

endmodule

/* rtl/sliding_window_extremum_with_position_top.sv */
// Sliding-window minimum/maximum with age of its oldest occurrence.
// Each item passes three states: in idle the sample is shifted into the ring of
// 2*MAX_RADIUS+1 cells, in scan the whole ring rotates once, one cell per step, past the
// single compare unit at cell 0, and in done the output register is loaded. The ring
// always makes a full turn, whatever the configured radius, so the scan does not depend
// on window_radius. A result left waiting in the output register does not block the next
// item; the block holds in its done state only when a second result is ready before the
// first was taken.
`include "sliding_window_extremum_with_position_top_defines.svh"

module sliding_window_extremum_with_position_top #(
   parameter int MAX_RADIUS  = swmx_pkg::MAX_RADIUS_DEFAULT,
   parameter int SAMPLE_BITS = swmx_pkg::SAMPLE_BITS_DEFAULT,
   localparam int DEPTH      = 2 * MAX_RADIUS + 1,
   localparam int AGE_BITS   = $clog2(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   input  logic                                  req_column_start,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [SAMPLE_BITS-1:0]                rsp_extremum,
   output logic [AGE_BITS-1:0]                   rsp_extremum_age,
   output logic                                  rsp_window_full,
   // configuration writes
   input  logic                                  csr_write_enable,
   input  logic [swmx_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [swmx_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam int MAXR_BITS = $clog2(MAX_RADIUS + 1);
   localparam int RAD_BITS  = (swmx_pkg::RADIUS_BITS > MAXR_BITS) ?
                              swmx_pkg::RADIUS_BITS : MAXR_BITS;

   // config registers
   logic [swmx_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [swmx_pkg::RADIUS_BITS-1:0] radius_in;
   logic                             find_max_ff;
   logic                             find_max_in;

   // control state
   swmx_pkg::state_type              state_ff;
   swmx_pkg::state_type              state_in;
   logic [AGE_BITS-1:0]              step_ff;
   logic [AGE_BITS-1:0]              step_in;
   logic [FILL_BITS-1:0]             fill_ff;
   logic [FILL_BITS-1:0]             fill_in;

   // output register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [SAMPLE_BITS-1:0]           rsp_extremum_ff;
   logic [SAMPLE_BITS-1:0]           rsp_extremum_in;
   logic [AGE_BITS-1:0]              rsp_age_ff;
   logic [AGE_BITS-1:0]              rsp_age_in;
   logic                             rsp_full_ff;
   logic                             rsp_full_in;

   logic                             accept;
   logic                             out_free;
   logic                             step_last;
   logic                             rsp_load;
   logic [RAD_BITS-1:0]              radius_ext;
   logic [RAD_BITS-1:0]              radius_eff;
   logic [FILL_BITS-1:0]             len_w;
   logic [FILL_BITS-1:0]             span;
   logic                             in_window;

   swmx_pkg::cell_ctrl_type          cell_ctrl;
   swmx_pkg::scan_ctrl_type          scan_ctrl;
   logic [SAMPLE_BITS-1:0]           cell_value [DEPTH];
   logic [SAMPLE_BITS-1:0]           best;
   logic [AGE_BITS-1:0]              best_age;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_last = (step_ff == AGE_BITS'(DEPTH - 1));

   // effective radius, clamped to 1..MAX_RADIUS, and window length 2R+1
   assign radius_ext = RAD_BITS'(radius_ff);
   always_comb begin
      radius_eff = radius_ext;
      if (radius_ext == '0) begin
         radius_eff = RAD_BITS'(1);
      end else if (radius_ext > RAD_BITS'(MAX_RADIUS)) begin
         radius_eff = RAD_BITS'(MAX_RADIUS);
      end
   end
   assign len_w = FILL_BITS'({radius_eff, 1'b1});

   // samples of this column that fall in the window
   assign span      = (fill_ff < len_w) ? fill_ff : len_w;
   assign in_window = (FILL_BITS'(step_ff) < span);

   // config port
   always_comb begin
      radius_in   = radius_ff;
      find_max_in = find_max_ff;
      if (csr_write_enable) begin
         case (csr_index)
            swmx_pkg::CSR_WINDOW_RADIUS: radius_in   = csr_write_data[swmx_pkg::RADIUS_BITS-1:0];
            swmx_pkg::CSR_FIND_MAX:      find_max_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmx_pkg::ST_IDLE: if (accept)    state_in = swmx_pkg::ST_SCAN;
         swmx_pkg::ST_SCAN: if (step_last) state_in = swmx_pkg::ST_DONE;
         swmx_pkg::ST_DONE: if (out_free)  state_in = swmx_pkg::ST_IDLE;
         default:                          state_in = swmx_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall            = 1'b1;
      cell_ctrl.shift_en   = 1'b0;
      cell_ctrl.rotate_en  = 1'b0;
      scan_ctrl.load_first = 1'b0;
      scan_ctrl.update_en  = 1'b0;
      rsp_load             = 1'b0;
      step_in              = step_ff;
      case (state_ff)
         swmx_pkg::ST_IDLE: begin
            req_stall          = 1'b0;
            cell_ctrl.shift_en = req_valid;
            step_in            = '0;
         end
         swmx_pkg::ST_SCAN: begin
            cell_ctrl.rotate_en  = 1'b1;
            scan_ctrl.load_first = (step_ff == '0);
            scan_ctrl.update_en  = in_window;
            step_in              = step_ff + AGE_BITS'(1);
         end
         swmx_pkg::ST_DONE: begin
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   // column fill count, restarted by a column start, saturating at the ring depth
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_column_start) begin
            fill_in = FILL_BITS'(1);
         end else if (fill_ff < FILL_BITS'(DEPTH)) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_extremum_in = rsp_extremum_ff;
      rsp_age_in      = rsp_age_ff;
      rsp_full_in     = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_extremum_in = best;
         rsp_age_in      = best_age;
         rsp_full_in     = (fill_ff >= len_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= swmx_pkg::RADIUS_RESET;
         find_max_ff  <= 1'b0;
         state_ff     <= swmx_pkg::ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         find_max_ff  <= find_max_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_extremum_ff <= rsp_extremum_in;
      rsp_age_ff      <= rsp_age_in;
      rsp_full_ff     <= rsp_full_in;
   end

   // ring of cells, newest at cell 0; rotation feeds cell 0 from the oldest side
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [SAMPLE_BITS-1:0] newer_value;
      logic [SAMPLE_BITS-1:0] older_value;

      if (k == 0) begin : g_head
         assign newer_value = req_sample;
      end else begin : g_body
         assign newer_value = cell_value[k-1];
      end

      if (k == DEPTH - 1) begin : g_tail
         assign older_value = cell_value[0];
      end else begin : g_link
         assign older_value = cell_value[k+1];
      end

      swmx_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .newer_value (newer_value),
         .older_value (older_value),
         .value       (cell_value[k])
      );
   end

   // compare unit watching cell 0
   swmx_scan #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS)
   ) u_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .find_max (find_max_ff),
      .tap      (cell_value[0]),
      .step     (step_ff),
      .best     (best),
      .best_age (best_age)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_extremum     = rsp_extremum_ff;
   assign rsp_extremum_age = rsp_age_ff;
   assign rsp_window_full  = rsp_full_ff;

   // an accepted item starts a scan from the newest sample
   `SWMX_ASSERT(a_accept_starts_scan, accept |=> (state_ff == swmx_pkg::ST_SCAN && step_ff == '0), "item accepted without a fresh scan")
   // the scan ends after exactly one full turn of the ring
   `SWMX_ASSERT(a_scan_turn, (state_ff == swmx_pkg::ST_SCAN && step_last) |=> (state_ff == swmx_pkg::ST_DONE), "scan did not end after one ring turn")
   // a fresh result always points inside the window
   `SWMX_ASSERT(a_age_in_window, $rose(rsp_valid_ff) |-> (FILL_BITS'(rsp_age_ff) < len_w), "result age outside the window")
   // after an item the column holds at least that sample and never more than the ring
   `SWMX_ASSERT_NEVER(a_fill_range, (fill_ff > FILL_BITS'(DEPTH)) || (state_ff != swmx_pkg::ST_IDLE && fill_ff == '0), "fill count out of range")

endmodule

/* test/sliding_window_extremum_with_position_top_tb.sv */
// Testbench for the sliding-window extremum block: directed and random items against a predictor.
`timescale 1ns / 100ps

module sliding_window_extremum_with_position_top_tb;

   localparam int MAX_R       = swmx_pkg::MAX_RADIUS_DEFAULT;
   localparam int SBITS       = swmx_pkg::SAMPLE_BITS_DEFAULT;
   localparam int DEPTH       = 2 * MAX_R + 1;
   localparam int AGE_W       = $clog2(DEPTH);
   localparam int IDX_W       = swmx_pkg::CSR_INDEX_BITS;
   localparam int DATA_W      = swmx_pkg::CSR_DATA_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 2 * MAX_R + 8;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 50;

   // indexes past the register list, which the block must ignore
   localparam logic [IDX_W-1:0] CSR_SPARE_2 = IDX_W'(2);
   localparam logic [IDX_W-1:0] CSR_SPARE_3 = IDX_W'(3);

   typedef struct packed {
      logic [SBITS-1:0] extremum;
      logic [AGE_W-1:0] age;
      logic             full;
   } window_result_type;

   // Predicts window extremum results and checks them in order
   class extremum_scoreboard;
      logic [SBITS-1:0] history[DEPTH];
      int unsigned      fill;
      logic [swmx_pkg::RADIUS_BITS-1:0] radius;
      logic             find_max;
      window_result_type expected_extrema[$];
      int               errors;
      int               checked;

      function new();
         foreach (history[i]) history[i] = '0;
         fill     = 0;
         radius   = swmx_pkg::RADIUS_RESET;
         find_max = 1'b0;
         errors   = 0;
         checked  = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         if (idx == swmx_pkg::CSR_WINDOW_RADIUS)
            radius = data[swmx_pkg::RADIUS_BITS-1:0];
         else if (idx == swmx_pkg::CSR_FIND_MAX)
            find_max = data[0];
      endfunction

      function int pending();
         return expected_extrema.size();
      endfunction

      // shift the new sample in and scan the window, oldest tie wins
      function void note_sample(logic [SBITS-1:0] s, logic col_start);
         int unsigned    r;
         int unsigned    len;
         int unsigned    n;
         int unsigned    best_age;
         logic [SBITS-1:0] best;
         window_result_type res;
         r = radius;
         if (r < 1) r = 1;
         if (r > MAX_R) r = MAX_R;
         len = 2 * r + 1;
         if (col_start) fill = 0;
         for (int k = DEPTH - 1; k > 0; k--) history[k] = history[k-1];
         history[0] = s;
         if (fill < DEPTH) fill++;
         n = (fill < len) ? fill : len;
         best     = history[0];
         best_age = 0;
         for (int k = 1; k < n; k++) begin
            if (find_max ? (history[k] >= best) : (history[k] <= best)) begin
               best     = history[k];
               best_age = k;
            end
         end
         res.extremum = best;
         res.age      = AGE_W'(best_age);
         res.full     = (fill >= len);
         expected_extrema.push_back(res);
      endfunction

      function void check_result(logic [SBITS-1:0] ext, logic [AGE_W-1:0] age, logic full);
         window_result_type exp_r;
         if (expected_extrema.size() == 0) begin
            $error("unexpected result item: extremum %0d age %0d full %0b", ext, age, full);
            errors++;
            return;
         end
         exp_r = expected_extrema.pop_front();
         checked++;
         if (ext !== exp_r.extremum) begin
            $error("extremum: expected %0d, actual %0d", exp_r.extremum, ext);
            errors++;
         end
         if (age !== exp_r.age) begin
            $error("extremum_age: expected %0d, actual %0d", exp_r.age, age);
            errors++;
         end
         if (full !== exp_r.full) begin
            $error("window_full: expected %0b, actual %0b", exp_r.full, full);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SBITS-1:0]          req_sample = '0;
   logic                      req_column_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SBITS-1:0]          rsp_extremum;
   logic [AGE_W-1:0]          rsp_extremum_age;
   logic                      rsp_window_full;
   logic                      csr_write_enable = 1'b0;
   logic [IDX_W-1:0]          csr_index = '0;
   logic [DATA_W-1:0]         csr_write_data = '0;

   extremum_scoreboard sb = new();
   bit          quiet = 1'b0;
   int          items_sent = 0;
   int          settings_used = 0;
   int unsigned cycle_count = 0;

   sliding_window_extremum_with_position_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_column_start (req_column_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_extremum     (rsp_extremum),
      .rsp_extremum_age (rsp_extremum_age),
      .rsp_window_full  (rsp_window_full),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // result side: check accepted items, then pick next stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_extremum, rsp_extremum_age, rsp_window_full);
         rsp_stall <= !reset && !quiet && ($urandom_range(0, 99) < 7);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sliding_window_extremum_with_position_top_tb failed");
      $finish;
   end

   // offer one item, holding it until taken; valid stays high between items unless a random gap is drawn
   task automatic send_item(input logic [SBITS-1:0] s, input logic col_start);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= s;
      req_column_start <= col_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(s, col_start);
      items_sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // mostly random content, with extremes and small values for ties
   function automatic logic [SBITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return SBITS'($urandom_range(0, 3));
         4:       return SBITS'($urandom_range(65530, 65535));
         default: return SBITS'($urandom);
      endcase
   endfunction

   task automatic random_phase(input logic [DATA_W-1:0] radius_code,
                               input logic max_sel, input bit pause_mid);
      int col_left;
      logic col_start;
      csr_write(swmx_pkg::CSR_WINDOW_RADIUS, radius_code);
      csr_write(swmx_pkg::CSR_FIND_MAX, {DATA_W'($urandom_range(0, 15)) << 1} | max_sel);
      settings_used++;
      col_left = $urandom_range(0, 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         col_start = 1'b0;
         if (col_left == 0) begin
            col_start = 1'b1;
            col_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(5, 45);
         end
         col_left--;
         if (pause_mid && i == PHASE_ITEMS / 2) drain();
         send_item(pick_sample(), col_start);
      end
      drain();
   endtask

   logic [DATA_W-1:0] radius_plan[RAND_PHASES] = '{16, 0, 4, 31, 1, 10, 17, 2};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: radius 1, minimum; partial fill, ties, new column
      send_item(16'd100, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd7, 1'b0);
      send_item(16'd0, 1'b1);
      send_item(16'hFFFF, 1'b0);
      drain();
      settings_used++;

      // spare indexes are ignored; radius zero acts as one; maximum mid-column
      csr_write(CSR_SPARE_2, DATA_W'($urandom));
      csr_write(CSR_SPARE_3, DATA_W'($urandom));
      csr_write(swmx_pkg::CSR_FIND_MAX, DATA_W'(1));
      csr_write(swmx_pkg::CSR_WINDOW_RADIUS, '0);
      settings_used++;
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd3, 1'b0);
      send_item(16'd0, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd1, 1'b0);
      drain();

      // oversize radius saturates; window grows within the running column
      csr_write(swmx_pkg::CSR_WINDOW_RADIUS, '1);
      csr_write(swmx_pkg::CSR_FIND_MAX, '0);
      settings_used++;
      for (int i = 0; i < 12; i++)
         send_item((i % 3 == 0) ? 16'h0000 : 16'h8000, 1'b0);
      drain();

      // random phases over several settings
      for (int p = 0; p < RAND_PHASES; p++) begin
         quiet = (p == 2);
         random_phase(radius_plan[p], (p < 2) ? logic'(p == 0) : logic'($urandom_range(0, 1)),
                      p == 5);
      end
      quiet = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items and checked %0d results across %0d register settings,",
               items_sent, sb.checked, settings_used);
      $display("covering min and max modes, clamped radii, ties and column restarts.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("sliding_window_extremum_with_position_top_tb passed");
      else
         $display("sliding_window_extremum_with_position_top_tb failed");
      $finish;
   end

endmodule
